FILE: rtl/core/fpa_pkg.sv
// Shared constants, codes and types of the Q24.8 fixed-point ALU.
`timescale 1ns / 1ps
package fpa_pkg;

    localparam int WORD_W    = 32;
    localparam int FRAC_BITS = 8;
    localparam int PROD_W    = 2 * WORD_W;
    localparam int NUM_W     = WORD_W + FRAC_BITS;   // scaled dividend width
    localparam int DIV_STEPS = NUM_W;                 // one quotient bit per stage
    localparam int MQ_DEPTH  = 2;
    localparam int MQ_PTR_W  = (MQ_DEPTH > 1) ? $clog2(MQ_DEPTH) : 1;
    localparam int MQ_CNT_W  = $clog2(MQ_DEPTH + 1);

    localparam logic [3:0] FN_ADD = 4'd0;
    localparam logic [3:0] FN_SUB = 4'd1;
    localparam logic [3:0] FN_MUL = 4'd2;
    localparam logic [3:0] FN_DIV = 4'd3;
    localparam logic [3:0] FN_MIN = 4'd4;
    localparam logic [3:0] FN_MAX = 4'd5;
    localparam logic [3:0] FN_I2F = 4'd6;
    localparam logic [3:0] FN_F2I = 4'd7;
    localparam logic [3:0] FN_INC = 4'd8;
    localparam logic [3:0] FN_DEC = 4'd9;

    typedef enum logic [1:0] {
        OP_PASS,
        OP_MUL,
        OP_DIV
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] res;
        logic              lt;
        logic              eq;
        logic              gt;
    } entry_t;

    typedef struct packed {
        op_t                      op;
        logic [WORD_W-1:0]        res;
        logic signed [PROD_W-1:0] prod;
        logic [NUM_W-1:0]         num;
        logic [WORD_W-1:0]        den;
        logic [WORD_W-1:0]        rem;
        logic [WORD_W-1:0]        quo;
        logic                     neg;
        logic                     dz;
        logic                     lt;
        logic                     eq;
        logic                     gt;
    } stage_t;

endpackage

FILE: rtl/core/fpa_front.sv
// Front end: accepts items, decodes func, computes flags and the results of all ops but mul and div.
`timescale 1ns / 1ps
module fpa_front (
    input  logic                        push,
    output logic                        full,
    input  logic [3:0]                  func,
    input  logic signed [fpa_pkg::WORD_W-1:0] operand_a,
    input  logic signed [fpa_pkg::WORD_W-1:0] operand_b,
    input  logic                        q_full,
    output logic                        q_push,
    output fpa_pkg::entry_t             q_din
);
    import fpa_pkg::*;

    logic lt;
    logic gt;

    assign full   = q_full;
    assign q_push = push && !q_full;
    assign lt     = operand_a < operand_b;
    assign gt     = operand_a > operand_b;

    always_comb
    begin
        q_din.a   = operand_a;
        q_din.b   = operand_b;
        q_din.lt  = lt;
        q_din.eq  = operand_a == operand_b;
        q_din.gt  = gt;
        q_din.op  = OP_PASS;
        q_din.res = '0;
        case (func)
            FN_ADD: q_din.res = operand_a + operand_b;
            FN_SUB: q_din.res = operand_a - operand_b;
            FN_MUL: q_din.op  = OP_MUL;
            FN_DIV: q_din.op  = OP_DIV;
            FN_MIN: q_din.res = lt ? operand_a : operand_b;
            FN_MAX: q_din.res = gt ? operand_a : operand_b;
            FN_I2F: q_din.res = operand_a << FRAC_BITS;
            FN_F2I: q_din.res = operand_a >>> FRAC_BITS;
            FN_INC: q_din.res = operand_a + WORD_W'(1);
            FN_DEC: q_din.res = operand_a - WORD_W'(1);
            default: q_din.res = '0;
        endcase
    end
endmodule

FILE: rtl/core/fpa_queue.sv
// Short register queue between front and back.
`timescale 1ns / 1ps
module fpa_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  fpa_pkg::entry_t din,
    output logic            full,
    input  logic            pop,
    output fpa_pkg::entry_t dout,
    output logic            empty
);
    import fpa_pkg::*;

    entry_t              mem_reg [0:MQ_DEPTH-1];
    logic [MQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [MQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [MQ_CNT_W-1:0] count_reg, count_next;

    assign full  = count_reg == MQ_CNT_W'(MQ_DEPTH);
    assign empty = count_reg == '0;
    assign dout  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == MQ_PTR_W'(MQ_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == MQ_PTR_W'(MQ_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= din;
    end
endmodule

FILE: rtl/core/fpa_back.sv
// Back end: multiplier, pipelined restoring divider and output register.
`timescale 1ns / 1ps
module fpa_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  fpa_pkg::entry_t                   q_dout,
    input  logic                              q_empty,
    output logic                              q_pop,
    output logic                              empty,
    input  logic                              pop,
    output logic signed [fpa_pkg::WORD_W-1:0] result_word,
    output logic                              a_less,
    output logic                              a_equal,
    output logic                              a_greater,
    output logic                              divide_by_zero
);
    import fpa_pkg::*;

    stage_t            stage_reg [0:DIV_STEPS];
    stage_t            stage_next [0:DIV_STEPS];
    logic              valid_reg [0:DIV_STEPS];
    logic              out_valid_reg, out_valid_next;
    logic [WORD_W-1:0] out_res_reg, out_res_next;
    logic              out_lt_reg, out_eq_reg, out_gt_reg, out_dz_reg;
    logic              en;

    logic signed [WORD_W-1:0] sa;
    logic signed [WORD_W-1:0] sb;
    logic [PROD_W-1:0]        adj;
    logic [WORD_W:0]          part;
    logic [WORD_W:0]          diff;

    // whole back pipe moves unless a finished item sits unclaimed
    assign en    = !out_valid_reg || pop;
    assign q_pop = en && !q_empty;

    always_comb
    begin
        sa = q_dout.a;
        sb = q_dout.b;
        stage_next[0].op   = q_dout.op;
        stage_next[0].res  = q_dout.res;
        stage_next[0].prod = sa * sb;
        stage_next[0].num  = {(q_dout.a[WORD_W-1] ? (~q_dout.a + 1'b1) : q_dout.a),
                              {FRAC_BITS{1'b0}}};
        stage_next[0].den  = q_dout.b[WORD_W-1] ? (~q_dout.b + 1'b1) : q_dout.b;
        stage_next[0].rem  = '0;
        stage_next[0].quo  = '0;
        stage_next[0].neg  = q_dout.a[WORD_W-1] ^ q_dout.b[WORD_W-1];
        stage_next[0].dz   = (q_dout.op == OP_DIV) && (q_dout.b == '0);
        stage_next[0].lt   = q_dout.lt;
        stage_next[0].eq   = q_dout.eq;
        stage_next[0].gt   = q_dout.gt;

        // truncate toward zero: bias negative products before the shift
        adj = stage_reg[0].prod + (stage_reg[0].prod[PROD_W-1] ?
                                   PROD_W'((1 << FRAC_BITS) - 1) : PROD_W'(0));

        // one restoring-division step per stage
        for (int k = 0; k < DIV_STEPS; k++)
        begin
            stage_next[k+1] = stage_reg[k];
            part = {stage_reg[k].rem, stage_reg[k].num[NUM_W-1]};
            diff = part - {1'b0, stage_reg[k].den};
            stage_next[k+1].num = stage_reg[k].num << 1;
            if (!diff[WORD_W])
            begin
                stage_next[k+1].rem = diff[WORD_W-1:0];
                stage_next[k+1].quo = {stage_reg[k].quo[WORD_W-2:0], 1'b1};
            end
            else
            begin
                stage_next[k+1].rem = part[WORD_W-1:0];
                stage_next[k+1].quo = {stage_reg[k].quo[WORD_W-2:0], 1'b0};
            end
            if (k == 0 && stage_reg[0].op == OP_MUL)
                stage_next[k+1].res = adj[FRAC_BITS+WORD_W-1:FRAC_BITS];
        end

        out_res_next = stage_reg[DIV_STEPS].res;
        if (stage_reg[DIV_STEPS].op == OP_DIV)
        begin
            if (stage_reg[DIV_STEPS].dz)
                out_res_next = '0;
            else if (stage_reg[DIV_STEPS].neg)
                out_res_next = ~stage_reg[DIV_STEPS].quo + 1'b1;
            else
                out_res_next = stage_reg[DIV_STEPS].quo;
        end
        out_valid_next = en ? valid_reg[DIV_STEPS] : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= DIV_STEPS; k++)
                valid_reg[k] <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (en)
            begin
                valid_reg[0] <= q_pop;
                for (int k = 0; k < DIV_STEPS; k++)
                    valid_reg[k+1] <= valid_reg[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k <= DIV_STEPS; k++)
                stage_reg[k] <= stage_next[k];
            out_res_reg <= out_res_next;
            out_lt_reg  <= stage_reg[DIV_STEPS].lt;
            out_eq_reg  <= stage_reg[DIV_STEPS].eq;
            out_gt_reg  <= stage_reg[DIV_STEPS].gt;
            out_dz_reg  <= stage_reg[DIV_STEPS].dz;
        end
    end

    assign empty          = !out_valid_reg;
    assign result_word    = out_res_reg;
    assign a_less         = out_lt_reg;
    assign a_equal        = out_eq_reg;
    assign a_greater      = out_gt_reg;
    assign divide_by_zero = out_dz_reg;
endmodule

FILE: rtl/core/fixed_point_q24_8_alu.sv
// Top level of the signed Q24.8 fixed-point ALU.
//
//  channel   direction  handshake          payload
//  input     in         push / full        func, operand_a, operand_b
//  result    out        empty / pop        result_word, a_less, a_equal, a_greater,
//                                          divide_by_zero
//
// Takes one item per cycle while full is low; every item runs the same back
// pipeline through the queue, the stage registers and the output register, whose
// depth is set by the divider, which resolves one quotient bit per stage.
// Reset (rst_n, async) empties the front queue, the pipe and the result register.
// An unclaimed result stalls the whole back pipe; the front keeps taking items
// until its two-entry queue fills, then raises full.
`timescale 1ns / 1ps
module fixed_point_q24_8_alu (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [3:0]                        func,
    input  logic signed [fpa_pkg::WORD_W-1:0] operand_a,
    input  logic signed [fpa_pkg::WORD_W-1:0] operand_b,
    output logic                              empty,
    input  logic                              pop,
    output logic signed [fpa_pkg::WORD_W-1:0] result_word,
    output logic                              a_less,
    output logic                              a_equal,
    output logic                              a_greater,
    output logic                              divide_by_zero
);
    import fpa_pkg::*;

    entry_t q_din;
    entry_t q_dout;
    logic   q_push;
    logic   q_pop;
    logic   q_full;
    logic   q_empty;

    // decode and cheap ops
    fpa_front u_front (
        .push      (push),
        .full      (full),
        .func      (func),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_din     (q_din)
    );

    // decouples front from a stalled back
    fpa_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_din),
        .full  (q_full),
        .pop   (q_pop),
        .dout  (q_dout),
        .empty (q_empty)
    );

    // mul, div, output register
    fpa_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_dout         (q_dout),
        .q_empty        (q_empty),
        .q_pop          (q_pop),
        .empty          (empty),
        .pop            (pop),
        .result_word    (result_word),
        .a_less         (a_less),
        .a_equal        (a_equal),
        .a_greater      (a_greater),
        .divide_by_zero (divide_by_zero)
    );

    // exactly one compare flag on every result
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> $onehot({a_less, a_equal, a_greater}))
        else $error("compare flags not one-hot");

    // divide by zero always yields a zero word
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && divide_by_zero) |-> (result_word == '0))
        else $error("divide by zero with nonzero result");

    // back never drains an empty queue
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("pop from empty front queue");
endmodule

FILE: tb/sv/fpa_result_checker.sv
// Checker for the Q24.8 ALU: predicts each item's result and compares it.
`timescale 1ns / 1ps
module fpa_result_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    input  logic                              full,
    input  logic [3:0]                        func,
    input  logic signed [fpa_pkg::WORD_W-1:0] operand_a,
    input  logic signed [fpa_pkg::WORD_W-1:0] operand_b,
    input  logic                              empty,
    input  logic                              pop,
    input  logic signed [fpa_pkg::WORD_W-1:0] result_word,
    input  logic                              a_less,
    input  logic                              a_equal,
    input  logic                              a_greater,
    input  logic                              divide_by_zero,
    output int                                fail_count,
    output int                                pending,
    output int                                items_in,
    output int                                results_out
);
    import fpa_pkg::*;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              lt;
        logic              eq;
        logic              gt;
        logic              dz;
    } alu_out_t;

    alu_out_t expected_q[$];

    function automatic alu_out_t alu_compute(logic [3:0] fn, logic signed [31:0] a,
                                             logic signed [31:0] b);
        alu_out_t          r;
        logic signed [63:0] p;
        logic [63:0]       mag, num, den;
        logic              neg;
        r = '0;
        r.lt = a < b;
        r.eq = a == b;
        r.gt = a > b;
        case (fn)
            FN_ADD: r.word = a + b;
            FN_SUB: r.word = a - b;
            FN_MUL:
            begin
                p = 64'(a) * 64'(b);
                mag = p < 0 ? -p : p;
                mag = mag >> FRAC_BITS;
                r.word = p < 0 ? -mag[31:0] : mag[31:0];
            end
            FN_DIV:
            begin
                if (b == 0)
                    r.dz = 1'b1;
                else
                begin
                    num = (a < 0 ? -64'(a) : 64'(a)) << FRAC_BITS;
                    den = b < 0 ? -64'(b) : 64'(b);
                    neg = (a < 0) != (b < 0);
                    mag = num / den;
                    r.word = neg ? -mag[31:0] : mag[31:0];
                end
            end
            FN_MIN: r.word = a < b ? a : b;
            FN_MAX: r.word = a > b ? a : b;
            FN_I2F: r.word = a << FRAC_BITS;
            FN_F2I: r.word = a >>> FRAC_BITS;
            FN_INC: r.word = a + 1;
            FN_DEC: r.word = a - 1;
            default: r.word = '0;
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        alu_out_t want, got;
        if (!rst_n)
        begin
            fail_count  <= 0;
            items_in    <= 0;
            results_out <= 0;
            pending     <= 0;
            expected_q.delete();
        end
        else
        begin
            if (push && !full)
            begin
                expected_q.push_back(alu_compute(func, operand_a, operand_b));
                items_in <= items_in + 1;
            end
            if (pop && !empty)
            begin
                results_out <= results_out + 1;
                got = {result_word, a_less, a_equal, a_greater, divide_by_zero};
                if (expected_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("%0t: unexpected result %h", $time, result_word);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got !== want)
                    begin
                        if (fail_count < 10)
                            $display({"%0t: mismatch exp w=%h l%b e%b g%b dz%b",
                                      " got w=%h l%b e%b g%b dz%b"},
                                     $time, want.word, want.lt, want.eq, want.gt, want.dz,
                                     got.word, got.lt, got.eq, got.gt, got.dz);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending <= expected_q.size();
        end
    end
endmodule

FILE: tb/sv/tb_fixed_point_q24_8_alu.sv
// Testbench top for the Q24.8 ALU: stimulus, idling, stalls and verdict.
`timescale 1ns / 1ps
module tb_fixed_point_q24_8_alu;
    import fpa_pkg::*;

    localparam int RANDOM_ITEMS = 1500;
    localparam int QUIET_TAIL   = 200;    // last items go with no idling
    localparam int WATCHDOG     = 5000;   // idle cycles before giving up

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [3:0]  func = '0;
    logic signed [31:0] operand_a = '0;
    logic signed [31:0] operand_b = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic signed [31:0] result_word;
    logic        a_less, a_equal, a_greater, divide_by_zero;
    int          fail_count, pending, items_in, results_out;

    // Flags shared between the sender and the receiver processes, and a count of divides by zero
    bit          quiet = 1'b0;        // no idling at all
    bit          long_hold = 1'b0;    // receiver holds off for a long stretch
    int          dz_seen = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    fixed_point_q24_8_alu dut (.*);

    fpa_result_checker checker_i (.*);

    // Operand picker: mostly random words, often with corner values and
    // small magnitudes so mul/div stay meaningful and b==0 shows up.
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return '0;
            3: return 32'(int'($urandom_range(0, 1024)) - 512);
            4: return 32'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
            5: return {$urandom_range(0, 1) ? 24'hffffff : 24'h0, 8'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    // Offer one item and hold it until accepted. Idling bursts come before.
    // push stays high after acceptance; drain_results, or an idling burst in the next call, drops it.
    task automatic send_item(logic [3:0] fn, logic [31:0] a, logic [31:0] b);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        push      <= 1'b1;
        func      <= fn;
        operand_a <= a;
        operand_b <= b;
        if (fn == FN_DIV && b == 0)
            dz_seen++;
        do
            @(posedge clk);
        while (full);
    endtask

    // Stop offering and wait until every expected result has come back
    task automatic drain_results();
        push <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
    endtask

    // Receiver: random pop with stall bursts; a long hold-off on request.
    initial
    begin
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                pop <= 1'b0;
                repeat (150) @(posedge clk);
                long_hold = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 6) == 0)
            begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 11) - 1) @(posedge clk);
            end
            else
                pop <= 1'b1;
        end
    end

    // Watchdog: counts cycles with no accepted item on either side
    initial
    begin
        int idle;
        idle = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty))
                idle = 0;
            else if (++idle >= WATCHDOG)
            begin
                $display("watchdog expired, %0d results outstanding", pending);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        logic [31:0] edges [4];
        edges = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: every code including unknown ones, extremes, div by zero
        for (int f = 0; f < 16; f++)
            send_item(4'(f), edges[f % 4], edges[(f + 1) % 4]);
        send_item(FN_DIV, 32'h0000_0100, '0);
        send_item(FN_DIV, 32'h8000_0000, 32'hffff_ffff);
        send_item(FN_MUL, 32'h8000_0000, 32'h8000_0000);
        send_item(FN_F2I, 32'hffff_ff01, '0);
        send_item(FN_I2F, 32'h00ff_ffff, '0);
        send_item(FN_MIN, 32'h1234_5678, 32'h1234_5678);
        send_item(FN_MAX, 32'h8000_0000, 32'h7fff_ffff);

        // Sender pause: let the pipe drain fully
        drain_results();
        long_hold = 1'b1;

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            logic [3:0] fn;
            logic [31:0] b;
            if (i == RANDOM_ITEMS - QUIET_TAIL)
                quiet = 1'b1;
            if (i == RANDOM_ITEMS / 2)
            begin
                drain_results();
                long_hold = 1'b1;
            end
            fn = $urandom_range(0, 15) < 14 ? 4'($urandom_range(0, 9)) : 4'($urandom);
            b = pick_operand();
            if (fn == FN_DIV && $urandom_range(0, 9) == 0)
                b = '0;
            send_item(fn, pick_operand(), b);
        end

        drain_results();
        repeat (60) @(posedge clk);
        $display("covered %0d items (%0d results), all ten codes plus unknown codes,",
                 items_in, results_out);
        $display("operand extremes, %0d divides by zero, long result stalls", dz_seen);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

FILE: files.f
rtl/core/fpa_pkg.sv
rtl/core/fpa_front.sv
rtl/core/fpa_queue.sv
rtl/core/fpa_back.sv
rtl/core/fixed_point_q24_8_alu.sv
tb/sv/fpa_result_checker.sv
tb/sv/tb_fixed_point_q24_8_alu.sv
